FILE: rtl/core/fcc_pkg.sv
// Shared types, register codes and constants for the floor/ceiling texcoord caster.
// Depends on nothing; the front, back, top level, checker and testbench import it.
`timescale 1ns / 1ps

package fcc_pkg;

	localparam int TEX_WIDTH_DEF  = 64;
	localparam int TEX_HEIGHT_DEF = 64;
	localparam int MAX_SCREEN_DEF = 4096;
	localparam int TEX_SIZE_W     = 13;
	localparam int DIM_W          = 14;
	localparam int DIV_NUM_W      = 32;
	localparam int DIV_DEN_W      = 14;
	localparam int MID_DEPTH      = 4;
	localparam int OUT_DEPTH      = 2;

	typedef enum logic [2:0] {
		REG_WINDOW_WIDTH  = 3'd0,
		REG_WINDOW_HEIGHT = 3'd1,
		REG_CAMERA_POS_X  = 3'd2,
		REG_CAMERA_POS_Y  = 3'd3,
		REG_VIEW_DIR_X    = 3'd4,
		REG_VIEW_DIR_Y    = 3'd5,
		REG_CAM_PLANE_X   = 3'd6,
		REG_CAM_PLANE_Y   = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic [11:0] pixel_col;
		logic [11:0] pixel_row;
		logic        row_begin;
	} pixel_t;

	typedef struct packed {
		logic [11:0] out_col;
		logic [11:0] floor_row;
		logic [11:0] ceil_row;
		logic [5:0]  texel_u;
		logic [5:0]  texel_v;
		logic        floor_ok;
		logic        ceil_ok;
		logic        horizon_fault;
	} result_t;

	// clamped window sizes and camera registers as the core sees them
	typedef struct packed {
		logic [DIM_W-1:0]  w_c;
		logic [DIM_W-1:0]  h_c;
		logic [23:0]       cam_x;
		logic [23:0]       cam_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] plane_x;
		logic signed [15:0] plane_y;
	} cfg_t;

	// classified item between front and back
	typedef struct packed {
		logic [11:0]          col;
		logic [11:0]          row;
		logic [11:0]          crow;
		logic                 fok;
		logic                 cok;
		logic                 fault;
		logic                 begin_row;
		logic [DIV_DEN_W-1:0] d2;
	} work_t;

endpackage

FILE: rtl/core/fcc_fifo.sv
// Small register queue used between front and back and at the result side.
// Depends on nothing but its type parameter.
`timescale 1ns / 1ps

module fcc_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     wr_data,
	input  logic rd_en,
	output T     rd_data,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_data;
	end

endmodule

FILE: rtl/core/fcc_front.sv
// Front part: classifies each pixel against the horizon and the window.
// Depends on fcc_pkg.
`timescale 1ns / 1ps

module fcc_front import fcc_pkg::*; (
	input  cfg_t   cfg,
	input  pixel_t pixel,
	output work_t  work
);

	logic signed [15:0] d2, ceil_r;
	logic               col_in;

	always_comb begin
		d2     = $signed({3'b0, pixel.pixel_row, 1'b0}) - $signed({2'b0, cfg.h_c});
		ceil_r = $signed({2'b0, cfg.h_c}) - $signed({4'b0, pixel.pixel_row}) - 16'sd1;
		col_in = ({2'b0, pixel.pixel_col} < cfg.w_c);

		work.col       = pixel.pixel_col;
		work.row       = pixel.pixel_row;
		work.begin_row = pixel.row_begin;
		work.fault     = (d2 <= 16'sd0);
		work.d2        = d2[DIV_DEN_W-1:0];
		work.crow      = (ceil_r >= 16'sd0) ? ceil_r[11:0] : 12'd0;
		work.fok       = !work.fault && col_in && ({2'b0, pixel.pixel_row} < cfg.h_c);
		work.cok       = !work.fault && col_in && (ceil_r >= 16'sd0)
		                 && (ceil_r < $signed({2'b0, cfg.h_c}));
	end

endmodule

FILE: rtl/core/fcc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; widths come from parameters.
`timescale 1ns / 1ps

module fcc_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W:0]   rem_q, rem_sh;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	assign rem_sh = {rem_q[DEN_W-1:0], quo[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quo    <= '0;
		end else begin
			done <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
				rem_q  <= '0;
				den_q  <= den;
				quo    <= num;
			end else if (busy_q) begin
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q};
					quo   <= {quo[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo   <= {quo[NUM_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/core/fcc_back.sv
// Back part: row setup sequencer, floor position stepping and texel forming.
// Depends on fcc_pkg and fcc_div.
`timescale 1ns / 1ps

module fcc_back import fcc_pkg::*; #(
	parameter int TEX_WIDTH  = TEX_WIDTH_DEF,
	parameter int TEX_HEIGHT = TEX_HEIGHT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  work_t   head,
	input  logic    mid_empty,
	output logic    mid_pop,
	input  logic    out_full,
	output logic    out_push,
	output result_t result
);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV_RD, S_MUL_T, S_MUL_O, S_DIV_X, S_DIV_Y, S_MUL_C, S_SUM, S_EMIT
	} state_t;

	state_t             state_q;
	work_t              cur_q, src;
	logic [28:0]        rd_q;
	logic signed [45:0] tx_q, ty_q;
	logic [31:0]        ox_q, oy_q, cx_q, cy_q;
	logic [31:0]        pos_x_q, pos_y_q, inc_x_q, inc_y_q;
	logic               neg_x_q, neg_y_q;

	logic                 div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quo;
	logic [DIV_DEN_W-1:0] div_den;

	logic                 emit;
	logic [2*TEX_SIZE_W+2:0] tu_p, tv_p;
	logic signed [46:0]   ox_p, oy_p;
	logic [45:0]          mag_x, mag_y;

	fcc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign ox_p  = $signed({1'b0, rd_q}) * ($signed({cfg.dir_x[15], cfg.dir_x})
	               - $signed({cfg.plane_x[15], cfg.plane_x}));
	assign oy_p  = $signed({1'b0, rd_q}) * ($signed({cfg.dir_y[15], cfg.dir_y})
	               - $signed({cfg.plane_y[15], cfg.plane_y}));
	assign mag_x = tx_q[45] ? 46'(-tx_q) : 46'(tx_q);
	assign mag_y = ty_q[45] ? 46'(-ty_q) : 46'(ty_q);

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		mid_pop   = 1'b0;
		emit      = 1'b0;
		src       = cur_q;
		case (state_q)
			S_IDLE: begin
				src = head;
				if (!mid_empty) begin
					if (head.begin_row && !head.fault) begin
						mid_pop   = 1'b1;
						div_start = 1'b1;
						div_num   = {2'b0, cfg.h_c[DIM_W-1:1], 1'b0, 16'b0};
						div_den   = head.d2;
					end else if (!out_full) begin
						mid_pop = 1'b1;
						emit    = 1'b1;
					end
				end
			end
			S_MUL_O: begin
				div_start = 1'b1;
				div_num   = mag_x[44:13];
				div_den   = cfg.w_c;
			end
			S_DIV_X: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num   = mag_y[44:13];
					div_den   = cfg.w_c;
				end
			end
			S_EMIT: emit = !out_full;
			default: ;
		endcase
	end

	always_comb begin
		tu_p = (2*TEX_SIZE_W+3)'(pos_x_q[15:0]) * (2*TEX_SIZE_W+3)'(TEX_WIDTH);
		tv_p = (2*TEX_SIZE_W+3)'(pos_y_q[15:0]) * (2*TEX_SIZE_W+3)'(TEX_HEIGHT);
		result.out_col       = src.col;
		result.floor_row     = src.row;
		result.ceil_row      = src.crow;
		result.texel_u       = src.fault ? 6'd0 : tu_p[21:16];
		result.texel_v       = src.fault ? 6'd0 : tv_p[21:16];
		result.floor_ok      = src.fok;
		result.ceil_ok       = src.cok;
		result.horizon_fault = src.fault;
		out_push             = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			rd_q    <= '0;
			tx_q    <= '0;
			ty_q    <= '0;
			ox_q    <= '0;
			oy_q    <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			neg_x_q <= 1'b0;
			neg_y_q <= 1'b0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			inc_x_q <= '0;
			inc_y_q <= '0;
		end else begin
			if (emit && !src.fault) begin
				pos_x_q <= pos_x_q + inc_x_q;
				pos_y_q <= pos_y_q + inc_y_q;
			end
			case (state_q)
				S_IDLE: begin
					if (div_start) begin
						cur_q   <= head;
						state_q <= S_DIV_RD;
					end
				end
				S_DIV_RD: begin
					if (div_done) begin
						rd_q    <= div_quo[28:0];
						state_q <= S_MUL_T;
					end
				end
				S_MUL_T: begin
					tx_q    <= $signed({1'b0, rd_q}) * cfg.plane_x;
					ty_q    <= $signed({1'b0, rd_q}) * cfg.plane_y;
					state_q <= S_MUL_O;
				end
				S_MUL_O: begin
					ox_q    <= ox_p[45:14];
					oy_q    <= oy_p[45:14];
					neg_x_q <= tx_q[45];
					neg_y_q <= ty_q[45];
					state_q <= S_DIV_X;
				end
				S_DIV_X: begin
					if (div_done) begin
						inc_x_q <= neg_x_q ? -div_quo : div_quo;
						state_q <= S_DIV_Y;
					end
				end
				S_DIV_Y: begin
					if (div_done) begin
						inc_y_q <= neg_y_q ? -div_quo : div_quo;
						state_q <= S_MUL_C;
					end
				end
				S_MUL_C: begin
					cx_q    <= 32'(44'(cur_q.col) * 44'(inc_x_q));
					cy_q    <= 32'(44'(cur_q.col) * 44'(inc_y_q));
					state_q <= S_SUM;
				end
				S_SUM: begin
					pos_x_q <= {8'b0, cfg.cam_x} + ox_q + cx_q;
					pos_y_q <= {8'b0, cfg.cam_y} + oy_q + cy_q;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/floor_ceiling_texcoord_caster_core.sv
// Top level: configuration registers, front classifier, middle queue, back and result queue.
// Depends on fcc_pkg, fcc_front, fcc_fifo, fcc_back.
//
// Takes below-horizon pixels and returns one floor texel coordinate and mirrored ceiling
// row per pixel, in order. A pixel that does not start a row passes straight through the
// back part, so a row streams at one pixel per clock while the result queue has room. A
// pixel with row_begin set (and below the horizon) runs the row setup: three passes of the
// shared 32-step radix-2 divider (row distance, then x and y step), with multiplies between
// and after them, then the sums and the output, during which the input queue of four items
// keeps taking pixels until it fills. Results wait in a two-entry queue. Configuration
// writes are always ready and must only happen while idle.
`timescale 1ns / 1ps

module floor_ceiling_texcoord_caster_core import fcc_pkg::*; #(
	parameter int TEX_WIDTH  = TEX_WIDTH_DEF,
	parameter int TEX_HEIGHT = TEX_HEIGHT_DEF,
	parameter int MAX_SCREEN = MAX_SCREEN_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  pixel_t   pixel,
	output logic     empty,
	input  logic     pop,
	output result_t  result,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_reg_e cfg_index,
	input  logic [23:0] cfg_data
);

	logic [12:0] width_q, height_q;
	logic [23:0] cam_x_q, cam_y_q;
	logic [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	cfg_t        cfg;
	work_t       work, head;
	logic        mid_empty, mid_pop, out_full, out_push;
	result_t     back_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 13'd640;
			height_q  <= 13'd480;
			cam_x_q   <= '0;
			cam_y_q   <= '0;
			dir_x_q   <= 16'hC000;
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= 16'd10813;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_WIDTH:  width_q   <= cfg_data[12:0];
				REG_WINDOW_HEIGHT: height_q  <= cfg_data[12:0];
				REG_CAMERA_POS_X:  cam_x_q   <= cfg_data;
				REG_CAMERA_POS_Y:  cam_y_q   <= cfg_data;
				REG_VIEW_DIR_X:    dir_x_q   <= cfg_data[15:0];
				REG_VIEW_DIR_Y:    dir_y_q   <= cfg_data[15:0];
				REG_CAM_PLANE_X:   plane_x_q <= cfg_data[15:0];
				REG_CAM_PLANE_Y:   plane_y_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.w_c = ({2'b0, width_q} > 15'(MAX_SCREEN)) ? DIM_W'(MAX_SCREEN) : {1'b0, width_q};
		if (width_q == '0)
			cfg.w_c = DIM_W'(1);
		cfg.h_c = ({2'b0, height_q} > 15'(MAX_SCREEN)) ? DIM_W'(MAX_SCREEN) : {1'b0, height_q};
		cfg.cam_x   = cam_x_q;
		cfg.cam_y   = cam_y_q;
		cfg.dir_x   = dir_x_q;
		cfg.dir_y   = dir_y_q;
		cfg.plane_x = plane_x_q;
		cfg.plane_y = plane_y_q;
	end

	fcc_front u_front (
		.cfg   (cfg),
		.pixel (pixel),
		.work  (work)
	);

	fcc_fifo #(.T(work_t), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (work),
		.rd_en   (mid_pop),
		.rd_data (head),
		.full    (full),
		.empty   (mid_empty)
	);

	fcc_back #(.TEX_WIDTH(TEX_WIDTH), .TEX_HEIGHT(TEX_HEIGHT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.result    (back_res)
	);

	fcc_fifo #(.T(result_t), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (back_res),
		.rd_en   (pop),
		.rd_data (result),
		.full    (out_full),
		.empty   (empty)
	);

endmodule

FILE: rtl/core/fcc_checker.sv
// Port-level checks for the caster core, bound to the top level.
// Depends on fcc_pkg.
`timescale 1ns / 1ps

module fcc_checker import fcc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before pop");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(result))
		else $error("result changed while waiting");

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.horizon_fault) |->
		(!result.floor_ok && !result.ceil_ok && result.texel_u == 6'd0
		 && result.texel_v == 6'd0))
		else $error("horizon fault with live coordinates");

	a_ceil: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.ceil_ok) |-> result.floor_ok)
		else $error("ceiling flag inconsistent");

endmodule

bind floor_ceiling_texcoord_caster_core fcc_checker u_fcc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

FILE: test/tb_floor_ceiling_texcoord_caster_core.sv
// Testbench for the floor/ceiling texcoord caster: a scoreboard class predicts each result
// from the camera registers and the floor-point state; random pixel rows and noise drive it.
// Depends on fcc_pkg and the floor_ceiling_texcoord_caster_core RTL.
`timescale 1ns / 1ps

module tb_floor_ceiling_texcoord_caster_core;
	import fcc_pkg::*;

	localparam int WATCHDOG = 20000;

	class texcoord_board;
		logic [23:0] regs [8];
		logic [31:0] pos_x, pos_y, inc_x, inc_y;
		result_t pending [$];
		int errors;
		int checked;

		function void init();
			regs[REG_WINDOW_WIDTH]  = 24'd640;
			regs[REG_WINDOW_HEIGHT] = 24'd480;
			regs[REG_CAMERA_POS_X]  = '0;
			regs[REG_CAMERA_POS_Y]  = '0;
			regs[REG_VIEW_DIR_X]    = 24'hC000;
			regs[REG_VIEW_DIR_Y]    = '0;
			regs[REG_CAM_PLANE_X]   = '0;
			regs[REG_CAM_PLANE_Y]   = 24'd10813;
			pos_x = 0; pos_y = 0; inc_x = 0; inc_y = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(cfg_reg_e idx, logic [23:0] val);
			if (idx == REG_WINDOW_WIDTH || idx == REG_WINDOW_HEIGHT)
				regs[idx] = val & 24'h1FFF;
			else if (idx == REG_CAMERA_POS_X || idx == REG_CAMERA_POS_Y)
				regs[idx] = val;
			else
				regs[idx] = val & 24'hFFFF;
		endfunction

		function longint floor14(longint p);
			longint q;
			q = p / 16384;
			if (p % 16384 < 0)
				q--;
			return q;
		endfunction

		function void note_pixel(pixel_t px);
			longint w, h, d2, cr, rd, sx, sy, ox, oy, dx, dy, plx, ply;
			result_t r;
			w = longint'(regs[REG_WINDOW_WIDTH]);
			h = longint'(regs[REG_WINDOW_HEIGHT]);
			if (w > 4096) w = 4096;
			if (w < 1) w = 1;
			if (h > 4096) h = 4096;
			d2 = 2 * longint'(px.pixel_row) - h;
			cr = h - longint'(px.pixel_row) - 1;
			r = '0;
			r.out_col = px.pixel_col;
			r.floor_row = px.pixel_row;
			r.ceil_row = (cr >= 0) ? cr[11:0] : 12'd0;
			r.horizon_fault = (d2 <= 0);
			if (d2 > 0) begin
				if (px.row_begin) begin
					dx = longint'($signed(regs[REG_VIEW_DIR_X][15:0]));
					dy = longint'($signed(regs[REG_VIEW_DIR_Y][15:0]));
					plx = longint'($signed(regs[REG_CAM_PLANE_X][15:0]));
					ply = longint'($signed(regs[REG_CAM_PLANE_Y][15:0]));
					rd = (2 * (h / 2) * 65536) / d2;
					sx = (rd * 2 * plx) / (w * 16384);
					sy = (rd * 2 * ply) / (w * 16384);
					ox = floor14(rd * (dx - plx));
					oy = floor14(rd * (dy - ply));
					inc_x = sx[31:0];
					inc_y = sy[31:0];
					pos_x = 32'(regs[REG_CAMERA_POS_X]) + ox[31:0] + 32'(px.pixel_col) * inc_x;
					pos_y = 32'(regs[REG_CAMERA_POS_Y]) + oy[31:0] + 32'(px.pixel_col) * inc_y;
				end
				r.texel_u = 6'((64'(pos_x[15:0]) * 64) >> 16);
				r.texel_v = 6'((64'(pos_y[15:0]) * 64) >> 16);
				pos_x += inc_x;
				pos_y += inc_y;
				r.floor_ok = (px.pixel_col < w) && (px.pixel_row < h);
				r.ceil_ok = (px.pixel_col < w) && (cr >= 0) && (cr < h);
			end
			pending.push_back(r);
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want, checked);
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report("unexpected item", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.out_col != want.out_col)
				report("out_col", int'(got.out_col), int'(want.out_col));
			if (got.floor_row != want.floor_row)
				report("floor_row", int'(got.floor_row), int'(want.floor_row));
			if (got.ceil_row != want.ceil_row)
				report("ceil_row", int'(got.ceil_row), int'(want.ceil_row));
			if (got.texel_u != want.texel_u)
				report("texel_u", int'(got.texel_u), int'(want.texel_u));
			if (got.texel_v != want.texel_v)
				report("texel_v", int'(got.texel_v), int'(want.texel_v));
			if (got.floor_ok != want.floor_ok)
				report("floor_ok", int'(got.floor_ok), int'(want.floor_ok));
			if (got.ceil_ok != want.ceil_ok)
				report("ceil_ok", int'(got.ceil_ok), int'(want.ceil_ok));
			if (got.horizon_fault != want.horizon_fault)
				report("horizon_fault", int'(got.horizon_fault), int'(want.horizon_fault));
			checked++;
		endtask
	endclass

	logic clk, arst_n, push, full, empty, pop, cfg_valid, cfg_ready;
	pixel_t pixel;
	result_t result;
	cfg_reg_e cfg_index;
	logic [23:0] cfg_data;

	texcoord_board board;
	int send_idle, recv_stall, idle_cycles, pushed, settings;

	floor_ceiling_texcoord_caster_core u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pixel(pixel),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				board.note_pixel(pixel);
			if (pop && !empty)
				board.check_result(result);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog expired with %0d items outstanding", board.pending.size());
				$display("tb_floor_ceiling_texcoord_caster_core failed");
				$finish;
			end
		end
	end

	always @(negedge clk)
		pop <= arst_n && ($urandom_range(99) >= recv_stall);

	task automatic write_cfg(cfg_reg_e idx, logic [23:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_pixel(int col, int row, bit beg);
		while ($urandom_range(99) < send_idle) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		pixel <= '{pixel_col: col[11:0], pixel_row: row[11:0], row_begin: beg};
		@(posedge clk);
		while (full) @(posedge clk);
		pushed++;
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic set_camera(int w, int h);
		write_cfg(REG_WINDOW_WIDTH, 24'(w));
		write_cfg(REG_WINDOW_HEIGHT, 24'(h));
		write_cfg(REG_CAMERA_POS_X, 24'($urandom_range(24'hFFFFFF)));
		write_cfg(REG_CAMERA_POS_Y, 24'($urandom_range(24'hFFFFFF)));
		write_cfg(REG_VIEW_DIR_X, 24'($urandom_range(16'hFFFF)));
		write_cfg(REG_VIEW_DIR_Y, 24'($urandom_range(16'hFFFF)));
		write_cfg(REG_CAM_PLANE_X, 24'($urandom_range(16'hFFFF)));
		write_cfg(REG_CAM_PLANE_Y, 24'($urandom_range(16'hFFFF)));
		settings++;
	endtask

	task automatic random_rows(int count);
		int w, h, row, col, len;
		w = int'(board.regs[REG_WINDOW_WIDTH]);
		h = int'(board.regs[REG_WINDOW_HEIGHT]);
		while (count > 0) begin
			if ($urandom_range(9) < 8) begin
				row = (h / 2) + 1 + $urandom_range((h > 4094 ? 4094 : h) / 2);
				if (row > 4095) row = 4095;
				col = $urandom_range(w > 4096 ? 4095 : w - 1);
				len = $urandom_range(40, 4);
				send_pixel(col, row, 1'b1);
				for (int i = 1; i < len; i++)
					send_pixel((col + i) & 12'hFFF, row, 1'b0);
				count -= len;
			end else begin
				send_pixel($urandom_range(4095), $urandom_range(4095), 1'($urandom_range(1)));
				count--;
			end
		end
	endtask

	initial begin
		board = new();
		board.init();
		arst_n = 0; push = 0; pop = 0; cfg_valid = 0;
		cfg_index = REG_WINDOW_WIDTH; cfg_data = 0; pixel = '0;
		send_idle = 0; recv_stall = 0; idle_cycles = 0; pushed = 0; settings = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset settings: state-less pixel, horizon rows, negative ceiling, wide columns
		send_pixel(5, 300, 1'b0);
		send_pixel(0, 0, 1'b1);
		send_pixel(10, 240, 1'b1);
		send_pixel(0, 241, 1'b1);
		send_pixel(1, 241, 1'b0);
		send_pixel(639, 479, 1'b1);
		send_pixel(640, 479, 1'b0);
		send_pixel(4095, 4095, 1'b1);
		send_pixel(4095, 4095, 1'b0);
		send_pixel(100, 600, 1'b0);
		drain();
		// zero width, oversize height, extreme camera values
		write_cfg(REG_WINDOW_WIDTH, 24'd0);
		write_cfg(REG_WINDOW_HEIGHT, 24'h1FFF);
		write_cfg(REG_CAMERA_POS_X, 24'hFFFFFF);
		write_cfg(REG_CAMERA_POS_Y, 24'hFFFFFF);
		write_cfg(REG_VIEW_DIR_X, 24'h8000);
		write_cfg(REG_VIEW_DIR_Y, 24'h7FFF);
		write_cfg(REG_CAM_PLANE_X, 24'h7FFF);
		write_cfg(REG_CAM_PLANE_Y, 24'h8000);
		send_pixel(0, 2049, 1'b1);
		send_pixel(1, 2049, 1'b0);
		send_pixel(0, 4095, 1'b1);
		send_pixel(0, 2048, 1'b1);
		drain();
		write_cfg(REG_WINDOW_WIDTH, 24'd1);
		write_cfg(REG_WINDOW_HEIGHT, 24'd2);
		send_pixel(0, 1, 1'b1);
		send_pixel(1, 1, 1'b0);
		send_pixel(0, 2, 1'b1);
		send_pixel(0, 0, 1'b1);
		drain();

		for (int p = 0; p < 16; p++) begin
			case (p % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 50; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 50; end
				default: begin send_idle = 34; recv_stall = 34; end
			endcase
			case (p % 5)
				0: set_camera(4096, 4096);
				1: set_camera(1, 2);
				default: set_camera($urandom_range(4096, 1), $urandom_range(4096, 2));
			endcase
			random_rows(102);
			drain();
		end
		send_idle = 0; recv_stall = 0;
		drain();

		$display("%0d pixels over %0d camera settings and four idling mixes, %0d results checked",
			pushed, settings, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb_floor_ceiling_texcoord_caster_core passed");
		else
			$display("tb_floor_ceiling_texcoord_caster_core failed");
		$finish;
	end
endmodule
